FILE: hw/rtl/bsed_pkg.sv
`timescale 1ns / 1ps

package bsed_pkg;

    // Action codes of a text request
    localparam logic [1:0] ACT_TEXT = 2'd0;
    localparam logic [1:0] ACT_EOA  = 2'd1;
    localparam logic [1:0] ACT_EOL  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE  = 1'd1;

    // Most result bytes that one request can cause
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned CNT_W   = 2;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'h1B;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_HEX0 = 3'd2,
        PH_HEX1 = 3'd3,
        PH_OCT  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } byte_item_t;

    typedef struct packed {
        logic escapes_enabled;
        logic trailing_newline;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] digit_value;
        logic [1:0] digits_left;
        logic       separator_pending;
        logic       output_stopped;
    } dec_state_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } res_group_t;

endpackage

FILE: hw/rtl/bsed_decode.sv
`timescale 1ns / 1ps

// Decode one request against the current line state: up to three result
// bytes and the state that follows.
module bsed_decode (
    input  bsed_pkg::text_item_t item,
    input  bsed_pkg::dec_state_t state,
    input  bsed_pkg::cfg_t       cfg,
    output bsed_pkg::dec_state_t state_next,
    output bsed_pkg::res_group_t group
);

    function automatic bsed_pkg::res_group_t push(bsed_pkg::res_group_t g, logic [7:0] b);
        bsed_pkg::res_group_t r;
        r = g;
        r.bytes[r.count] = b;
        r.count = r.count + bsed_pkg::CNT_W'(1);
        return r;
    endfunction

    logic [7:0] c;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_oct;
    logic [8:0] oct_value;
    logic [1:0] left_dec;

    always_comb
    begin
        c = item.char_byte;
        is_hex = 1'b0;
        hex_val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            is_hex = 1'b1;
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            is_hex = 1'b1;
            hex_val = c[3:0] + 4'd9;
        end
        is_oct = (c >= 8'h30) && (c <= 8'h37);
        oct_value = {state.digit_value[5:0], c[2:0]};
        left_dec = state.digits_left - 2'd1;
    end

    // Flush the pending sequence of the current state into a group.
    function automatic bsed_pkg::res_group_t flush(bsed_pkg::res_group_t g,
                                                   bsed_pkg::dec_state_t s);
        bsed_pkg::res_group_t r;
        r = g;
        unique case (s.phase)
            bsed_pkg::PH_BSL:  r = push(r, bsed_pkg::CH_BSL);
            bsed_pkg::PH_HEX0:
            begin
                r = push(r, bsed_pkg::CH_BSL);
                r = push(r, 8'h78);
            end
            bsed_pkg::PH_HEX1,
            bsed_pkg::PH_OCT:  r = push(r, s.digit_value[7:0]);
            default:           r = g;
        endcase
        return r;
    endfunction

    always_comb
    begin
        bsed_pkg::dec_state_t s;
        bsed_pkg::res_group_t g;
        logic                 plain;
        s = state;
        g = '0;
        plain = 1'b0;

        if (item.action == bsed_pkg::ACT_EOL)
        begin
            if (!state.output_stopped)
            begin
                g = flush(g, state);
                if (cfg.trailing_newline)
                begin
                    g = push(g, bsed_pkg::CH_LF);
                end
            end
            s = '0;
        end
        else if ((item.action == bsed_pkg::ACT_TEXT || item.action == bsed_pkg::ACT_EOA)
                 && !state.output_stopped)
        begin
            if (state.separator_pending)
            begin
                g = push(g, bsed_pkg::CH_SPACE);
                s.separator_pending = 1'b0;
            end
            if (item.action == bsed_pkg::ACT_EOA)
            begin
                g = flush(g, state);
                s.phase = bsed_pkg::PH_IDLE;
                s.digit_value = '0;
                s.digits_left = '0;
                s.separator_pending = 1'b1;
            end
            else
            begin
                // Any path that falls back to plain text clears the sequence first
                unique case (state.phase)
                    bsed_pkg::PH_BSL:
                    begin
                        s.phase = bsed_pkg::PH_IDLE;
                        s.digit_value = '0;
                        s.digits_left = '0;
                        unique case (c)
                            8'h61: g = push(g, 8'h07);
                            8'h62: g = push(g, 8'h08);
                            8'h65: g = push(g, bsed_pkg::CH_ESC);
                            8'h66: g = push(g, 8'h0C);
                            8'h6E: g = push(g, 8'h0A);
                            8'h72: g = push(g, 8'h0D);
                            8'h74: g = push(g, 8'h09);
                            8'h76: g = push(g, 8'h0B);
                            8'h5C: g = push(g, bsed_pkg::CH_BSL);
                            8'h63: s.output_stopped = 1'b1;
                            8'h78: s.phase = bsed_pkg::PH_HEX0;
                            8'h30:
                            begin
                                s.phase = bsed_pkg::PH_OCT;
                                s.digits_left = 2'd3;
                            end
                            default:
                            begin
                                if (is_oct)
                                begin
                                    s.phase = bsed_pkg::PH_OCT;
                                    s.digit_value = {6'd0, c[2:0]};
                                    s.digits_left = 2'd2;
                                end
                                else
                                begin
                                    g = push(g, bsed_pkg::CH_BSL);
                                    g = push(g, c);
                                end
                            end
                        endcase
                    end
                    bsed_pkg::PH_HEX0:
                    begin
                        if (is_hex)
                        begin
                            s.phase = bsed_pkg::PH_HEX1;
                            s.digit_value = {5'd0, hex_val};
                        end
                        else
                        begin
                            g = flush(g, state);
                            plain = 1'b1;
                        end
                    end
                    bsed_pkg::PH_HEX1:
                    begin
                        if (is_hex)
                        begin
                            g = push(g, {state.digit_value[3:0], hex_val});
                            s.phase = bsed_pkg::PH_IDLE;
                            s.digit_value = '0;
                            s.digits_left = '0;
                        end
                        else
                        begin
                            g = flush(g, state);
                            plain = 1'b1;
                        end
                    end
                    bsed_pkg::PH_OCT:
                    begin
                        if (is_oct && state.digits_left != 2'd0)
                        begin
                            if (left_dec == 2'd0)
                            begin
                                g = push(g, oct_value[7:0]);
                                s.phase = bsed_pkg::PH_IDLE;
                                s.digit_value = '0;
                                s.digits_left = '0;
                            end
                            else
                            begin
                                s.digit_value = oct_value;
                                s.digits_left = left_dec;
                            end
                        end
                        else
                        begin
                            g = flush(g, state);
                            plain = 1'b1;
                        end
                    end
                    default:
                    begin
                        plain = 1'b1;
                    end
                endcase

                if (plain)
                begin
                    s.phase = bsed_pkg::PH_IDLE;
                    s.digit_value = '0;
                    s.digits_left = '0;
                    if (c == bsed_pkg::CH_BSL && cfg.escapes_enabled)
                    begin
                        s.phase = bsed_pkg::PH_BSL;
                    end
                    else
                    begin
                        g = push(g, c);
                    end
                end
            end
        end

        state_next = s;
        group = g;
    end

endmodule

FILE: hw/rtl/bsed_out_buf.sv
`timescale 1ns / 1ps

// Result register: holds one group of result bytes and hands them out one
// per cycle while byte_stall is low.
module bsed_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bsed_pkg::res_group_t group,
    output logic                 load_ok,
    output logic                 byte_valid,
    input  logic                 byte_stall,
    output bsed_pkg::byte_item_t byte_item
);

    logic [bsed_pkg::MAX_RES-1:0][7:0] bytes_reg;
    logic [bsed_pkg::CNT_W-1:0]        left_reg;
    logic                              taken;

    assign byte_valid = (left_reg != '0);
    assign taken      = byte_valid && !byte_stall;
    assign load_ok    = (left_reg == '0) ||
                        (left_reg == bsed_pkg::CNT_W'(1) && taken);

    assign byte_item.out_byte = bytes_reg[0];
    assign byte_item.run_last = (left_reg == bsed_pkg::CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (load)
        begin
            left_reg <= group.count;
        end
        else if (taken)
        begin
            left_reg <= left_reg - bsed_pkg::CNT_W'(1);
        end
    end

    // Advance the bytes toward slot 0 as each one is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= group.bytes;
        end
        else if (taken)
        begin
            bytes_reg <= {8'h00, bytes_reg[bsed_pkg::MAX_RES-1:1]};
        end
    end

endmodule

FILE: hw/rtl/backslash_escape_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// text     in         text_valid/stall     text_item (action, char_byte)
// byte     out        byte_valid/stall     byte_item (out_byte, run_last)
// cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
// A text request is registered, then decoded in one pass into a group of up
// to three result bytes, which the result register hands out one per cycle
// while byte_stall is low. Requests with one or no result flow at one per
// cycle; more results hold the next request in its register (one byte port).
// Reset clears the line state and the buffers; escapes start off, newline on.
// A stall on the byte side backs up into text_stall once both stages fill.
module backslash_escape_decoder (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               text_valid,
    output logic                               text_stall,
    input  bsed_pkg::text_item_t               text_item,

    output logic                               byte_valid,
    input  logic                               byte_stall,
    output bsed_pkg::byte_item_t               byte_item,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_data
);

    // Input register
    logic                 in_valid_reg;
    bsed_pkg::text_item_t in_item_reg;

    // Line state, updated as each request leaves the input register
    bsed_pkg::dec_state_t state_reg;
    bsed_pkg::dec_state_t state_next;

    bsed_pkg::cfg_t       cfg_reg;
    bsed_pkg::res_group_t group;
    logic                 load_ok;
    logic                 consume;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escapes_enabled  <= 1'b0;
            cfg_reg.trailing_newline <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bsed_pkg::CFG_ESCAPES: cfg_reg.escapes_enabled  <= cfg_data;
                bsed_pkg::CFG_NEWLINE: cfg_reg.trailing_newline <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Move the registered request on once the result register can take its group
    assign consume    = in_valid_reg && load_ok;
    assign text_stall = in_valid_reg && !load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (!text_stall)
        begin
            in_item_reg <= text_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    bsed_decode u_decode (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .group      (group)
    );

    bsed_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume),
        .group      (group),
        .load_ok    (load_ok),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item)
    );

endmodule
